// ===== rtl/flp50_pkg.sv =====
// Constants, coefficient table and state encoding for the 50-tap low-pass FIR.
package flp50_pkg;

  localparam int TAPS           = 50;
  localparam int SAMPLE_WIDTH   = 16;
  localparam int COEF_FRAC_BITS = 15;

  localparam int ROM_FRAC_BITS  = 24;
  localparam int ROM_TAPS       = 50;
  localparam int HALF_TAPS      = 25;
  localparam int ROM_SHIFT      = ROM_FRAC_BITS - COEF_FRAC_BITS;
  localparam int ROM_ROUND      = (ROM_SHIFT > 0) ? (1 << (ROM_SHIFT - 1)) : 0;

  localparam int IDX_W  = $clog2(TAPS);
  localparam int COEF_W = COEF_FRAC_BITS + 1;
  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;
  localparam int RND_W  = ACC_W + 1;

  localparam int ROM_HALF [HALF_TAPS] = '{
    6591, 16101, 22414, 21603, 8981,
    -17081, -50696, -76886, -75696, -32009,
    52721, 153209, 223560, 213073, 90634,
    -131864, -388656, -570182, -554698, -252538,
    352869, 1184206, 2080620, 2838943, 3273390
  };

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MAC  = 4'b0010,
    S_ADD  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  function automatic logic signed [COEF_W-1:0] coef_at(input logic [IDX_W-1:0] idx);
    int k;
    int t;
    k = int'(idx);
    t = 0;
    if (k < ROM_TAPS) begin
      if (k >= HALF_TAPS) begin
        k = ROM_TAPS - 1 - k;
      end
      t = ROM_HALF[k];
      if (ROM_SHIFT > 0) begin
        t = (t + ROM_ROUND) >>> ROM_SHIFT;
      end
    end
    return t[COEF_W-1:0];
  endfunction

endpackage

// ===== rtl/fir_lowpass_50_tap_unit.sv =====
// Top level: 50-tap low-pass FIR with one shared multiply-accumulate unit.
// Sample beat: S_MAC steps through the taps, S_ADD adds the last product, S_OUT registers the result.
// Restart beat: S_OUT registers a zero result; the delay line is cleared at once on accept.
// Rate is set by the single multiplier stepping once per tap over a rotating delay line.
// A result waits in the output register while the next input beat is taken.
// Synchronous active-low reset clears control state and zeroes the delay line.
module fir_lowpass_50_tap_unit
  import flp50_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_filtered
);

  localparam logic signed [RND_W-1:0] SMAX = RND_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0] SMIN = -SMAX - RND_W'(1);
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (COEF_FRAC_BITS - 1);

  state_t                         state_r, state_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic signed [SAMPLE_WIDTH-1:0] hist_r [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] hist_nxt [TAPS];
  logic signed [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [ACC_W-1:0]        acc_r, acc_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic signed [15:0]             out_filtered_r, out_filtered_nxt;
  logic signed [RND_W-1:0]        rnd;
  logic signed [RND_W-1:0]        sat;
  logic                           in_take;
  logic                           out_free;

  assign in_stall     = (state_r != S_IDLE);
  assign in_take      = in_valid && (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_free     = !out_valid_r || !out_stall;

  always_comb begin
    rnd = (RND_W'(acc_r) + HALF) >>> COEF_FRAC_BITS;
    if (rnd > SMAX) begin
      sat = SMAX;
    end else if (rnd < SMIN) begin
      sat = SMIN;
    end else begin
      sat = rnd;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    idx_nxt          = idx_r;
    prod_nxt         = prod_r;
    acc_nxt          = acc_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_filtered_nxt = out_filtered_r;
    hist_nxt         = hist_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          acc_nxt  = '0;
          prod_nxt = '0;
          idx_nxt  = '0;
          if (in_cmd) begin
            for (int i = 0; i < TAPS; i++) begin
              hist_nxt[i] = '0;
            end
            state_nxt = S_OUT;
          end else begin
            hist_nxt[0] = in_sample[SAMPLE_WIDTH-1:0];
            for (int i = 1; i < TAPS; i++) begin
              hist_nxt[i] = hist_r[i-1];
            end
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        prod_nxt = hist_r[0] * coef_at(idx_r);
        acc_nxt  = acc_r + ACC_W'(prod_r);
        for (int i = 0; i < TAPS - 1; i++) begin
          hist_nxt[i] = hist_r[i+1];
        end
        hist_nxt[TAPS-1] = hist_r[0];
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(TAPS - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        acc_nxt   = acc_r + ACC_W'(prod_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_filtered_nxt = sat[15:0];
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      hist_r      <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r         <= prod_nxt;
    acc_r          <= acc_nxt;
    out_filtered_r <= out_filtered_nxt;
  end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the 50-tap low-pass FIR with restart command.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS      = flp50_pkg::TAPS;
  localparam int FRAC      = flp50_pkg::COEF_FRAC_BITS;
  localparam int Q24_SHIFT = 24 - FRAC;
  localparam int SMAX      = 32767;
  localparam int SMIN      = -32768;
  localparam logic CMD_FILTER  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  localparam int HALF_Q24 [25] = '{
    6591, 16101, 22414, 21603, 8981,
    -17081, -50696, -76886, -75696, -32009,
    52721, 153209, 223560, 213073, 90634,
    -131864, -388656, -570182, -554698, -252538,
    352869, 1184206, 2080620, 2838943, 3273390
  };

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] sample;
  } flow_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = 1'b0;
  logic signed [15:0] in_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_filtered;

  flow_beat_t         flow_pending [$];
  logic signed [15:0] filtered_due [$];
  logic signed [15:0] delay_line [TAPS];
  int                 coef_q15 [TAPS];

  int   taken_n = 0;
  int   total_n = 0;
  int   err_n = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic calm = 1'b0;
  int   idle_pct = 0;
  int   cyc = 0;

  fir_lowpass_50_tap_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_filtered (out_filtered)
  );

  always #2 clk = ~clk;

  function automatic logic signed [15:0] next_filtered(input logic cmd,
                                                        input logic signed [15:0] smp);
    longint acc;
    longint y;
    int     i;
    if (cmd == CMD_RESTART) begin
      for (i = 0; i < TAPS; i++) delay_line[i] = '0;
      return '0;
    end
    for (i = TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
    delay_line[0] = smp;
    acc = 0;
    for (i = 0; i < TAPS; i++) acc += longint'(delay_line[i]) * longint'(coef_q15[i]);
    y = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
    if (y > SMAX) y = SMAX;
    if (y < SMIN) y = SMIN;
    return y[15:0];
  endfunction

  function automatic void queue_beat(input logic cmd, input int smp);
    flow_beat_t b;
    b.cmd    = cmd;
    b.sample = smp[15:0];
    flow_pending.push_back(b);
    total_n++;
  endfunction

  function automatic int edge_value(input int s);
    return (s > 0) ? SMAX : SMIN;
  endfunction

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: idle_pct <= 0;
        1: idle_pct <= 5;
        2: idle_pct <= 15;
        default: idle_pct <= 35;
      endcase
    end
  end

  // sender
  always @(posedge clk) begin : drive
    logic       take;
    logic       nv;
    flow_beat_t nb;
    int         gap_left;
    take = in_valid && !in_stall;
    nv   = in_valid && !take;
    if (!rst_n) begin
      gap_left = 0;
      in_valid <= 1'b0;
    end else begin
      if (take) begin
        filtered_due.push_back(next_filtered(in_cmd, in_sample));
        taken_n <= taken_n + 1;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
          gap_left = $urandom_range(0, 12);
        end else if (flow_pending.size() > 0) begin
          nb = flow_pending.pop_front();
          nv = 1'b1;
          in_cmd    <= nb.cmd;
          in_sample <= nb.sample;
        end
      end
      in_valid <= nv;
      calm     <= (flow_pending.size() < 60);
    end
  end

  // hold off the sink long enough to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && taken_n >= 120) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver
  always @(posedge clk) begin : sink
    int stall_left;
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left--;
      end else if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        stall_left = $urandom_range(1, 13);
      end
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk) begin : watch
    logic signed [15:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_due.size() == 0) begin
        err_n++;
        if (err_n <= 10) $display("unexpected result beat: filtered=%0d", out_filtered);
      end else begin
        want = filtered_due.pop_front();
        if (out_filtered !== want) begin
          err_n++;
          if (err_n <= 10) begin
            $display("filtered mismatch: expected %0d actual %0d", want, out_filtered);
          end
        end
      end
    end
  end

  initial begin : run
    int k;
    int n;
    int len;
    int s;
    for (k = 0; k < TAPS; k++) begin
      coef_q15[k] = (HALF_Q24[(k < 25) ? k : (49 - k)] + (1 << (Q24_SHIFT - 1))) >>> Q24_SHIFT;
      delay_line[k] = '0;
    end

    queue_beat(CMD_RESTART, SMIN);
    queue_beat(CMD_FILTER, SMAX);
    queue_beat(CMD_FILTER, SMIN);
    queue_beat(CMD_FILTER, 0);
    queue_beat(CMD_FILTER, 1);
    queue_beat(CMD_FILTER, -1);
    queue_beat(CMD_FILTER, 16384);
    queue_beat(CMD_FILTER, -16384);
    queue_beat(CMD_RESTART, SMAX);
    for (k = 0; k < 6; k++) queue_beat(CMD_FILTER, SMIN);
    for (k = 0; k < 6; k++) queue_beat(CMD_FILTER, SMAX);
    queue_beat(CMD_RESTART, 0);
    queue_beat(CMD_FILTER, 1);

    while (total_n < 500) begin
      len = $urandom_range(10, 60);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (n = 0; n < len; n++) begin
            queue_beat(($urandom_range(0, 99) < 3) ? CMD_RESTART : CMD_FILTER, $urandom);
          end
        end
        4: begin
          // sign-matched run drives the sum past full scale
          s = $urandom_range(0, 1) ? 1 : -1;
          len = $urandom_range(50, 56);
          for (n = 0; n < len; n++) queue_beat(CMD_FILTER, edge_value(s * coef_q15[n % TAPS]));
        end
        5: begin
          for (n = 0; n < len; n++) queue_beat(CMD_FILTER, $signed($urandom_range(0, 6)) - 3);
        end
        6: begin
          s = $urandom;
          for (n = 0; n < len; n++) queue_beat(CMD_FILTER, s);
        end
        7: queue_beat(CMD_RESTART, $urandom);
        8: begin
          for (n = 0; n < len; n++) begin
            case ($urandom_range(0, 4))
              0: s = SMAX;
              1: s = SMIN;
              2: s = 0;
              3: s = 1;
              default: s = -1;
            endcase
            queue_beat(CMD_FILTER, s);
          end
        end
        default: begin
          len = $urandom_range(5, 15);
          for (n = 0; n < len; n++) queue_beat(1'($urandom_range(0, 1)), $urandom);
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (taken_n < total_n || filtered_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (err_n == 0 && filtered_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAIL");
    $finish;
  end

endmodule
